// ===== rtl/core/epr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epr_pkg - echo pulse range filter shared definitions
// Field widths, ranging constants, command and register codes, sequencer
// states and the control/status structs between top level and ring walker.
// ----------------------------------------------------------------------------
package epr_pkg;

	localparam int TC_W          = 16;
	localparam int WRAP_W        = 8;
	localparam int DIST_W        = 27;
	localparam int HIT_W         = 22;
	localparam int MISS_W        = 8;
	localparam int CFG_W         = 22;
	localparam int DVS_W         = 7;
	localparam int PROD_W        = WRAP_W + 1 + TC_W;
	localparam int WIDE_W        = PROD_W + 1;
	localparam int DIST_NUM_W    = PROD_W + 8;
	localparam int OUT_W         = 80;
	localparam int RING_DEPTH_DEF = 10;

	localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
	localparam logic [DIST_W-1:0] NEAR_Q8    = DIST_W'(512);
	localparam logic [DIST_W-1:0] FAR_Q8     = DIST_W'(12800);
	localparam logic [HIT_W-1:0]  HIT_WRAP   = HIT_W'(4000000);
	localparam logic [MISS_W-1:0] MISS_LIMIT = MISS_W'(5);
	localparam logic [DVS_W-1:0]  DIST_DIV   = DVS_W'(58);
	localparam logic [DIST_NUM_W-1:0] ROUND_BIAS = DIST_NUM_W'(29);
	localparam logic [TC_W-1:0]   PERIOD_RST = {TC_W{1'b1}};
	localparam logic [HIT_W-1:0]  THRESH_RST = HIT_W'(100);
	localparam logic [WRAP_W-1:0] WRAP_SAT   = {WRAP_W{1'b1}};

	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_WRAP = 1'b1;

	localparam logic REG_TIMER_PERIOD  = 1'b0;
	localparam logic REG_HIT_THRESHOLD = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_NUM,
		ST_DIST_GO,
		ST_DIST_WAIT,
		ST_WRITE,
		ST_WALK_GO,
		ST_WALK,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_PUSH
	} state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_EST,
		DV_BACK,
		DV_FIX
	} div_state_t;

	typedef struct packed {
		logic write;
		logic walk_start;
	} ring_ctl_t;

	typedef struct packed {
		logic walk_done;
		logic lost;
		logic acquired;
	} ring_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/epr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epr_div - shared constant divider
// Reciprocal multiply for a quotient estimate, back multiply for the
// remainder, then compare-and-subtract steps until the remainder is in range.
// ----------------------------------------------------------------------------
module epr_div #(
	parameter int NUM_W      = epr_pkg::DIST_NUM_W,
	parameter int RING_DEPTH = epr_pkg::RING_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             mean_sel,   // 1: divide by RING_DEPTH, 0: by 58
	input  logic [NUM_W-1:0] numer,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	import epr_pkg::*;

	localparam int RCP_SHIFT = 32;
	localparam int RCP_W     = 32;
	localparam int REM_W     = 10;
	localparam int MUL_W     = NUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP_DIST = RCP_W'((64'd1 << RCP_SHIFT) / 64'(DIST_DIV));
	localparam logic [RCP_W-1:0] RCP_MEAN = RCP_W'((64'd1 << RCP_SHIFT) / 64'(RING_DEPTH));
	localparam logic [DVS_W-1:0] MEAN_DIV = DVS_W'(RING_DEPTH);

	div_state_t state_q, state_d;

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quot_q;
	logic [REM_W-1:0] rem_q;
	logic             sel_q;

	logic [DVS_W-1:0] dvs;
	logic [NUM_W-1:0] mul_a;
	logic [RCP_W-1:0] mul_b;
	logic [MUL_W-1:0] mul_p;
	logic             fits;

	assign dvs   = sel_q ? MEAN_DIV : DIST_DIV;
	assign fits  = rem_q >= REM_W'(dvs);
	assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: if (start) state_d = DV_EST;
			DV_EST:  state_d = DV_BACK;
			DV_BACK: state_d = DV_FIX;
			DV_FIX:  if (!fits) state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	always_comb begin
		mul_a = (state_q == DV_EST) ? num_q : quot_q;
		mul_b = (state_q == DV_EST) ? (sel_q ? RCP_MEAN : RCP_DIST) : RCP_W'(dvs);
		done  = (state_q == DV_FIX) && !fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// estimate is never above the quotient and at most two below it
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			num_q <= numer;
			sel_q <= mean_sel;
		end
		if (state_q == DV_EST)
			quot_q <= mul_p[RCP_SHIFT +: NUM_W];
		if (state_q == DV_BACK)
			rem_q <= num_q[REM_W-1:0] - mul_p[REM_W-1:0];
		if (state_q == DV_FIX && fits) begin
			rem_q  <= rem_q - REM_W'(dvs);
			quot_q <= quot_q + NUM_W'(1);
		end
	end

	assign quot = quot_q;

endmodule
`default_nettype wire

// ===== rtl/core/epr_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epr_ring - distance ring and hit/miss walker
// Ring memory with per-entry valid bits; walks one entry per cycle,
// accumulating the sum and updating hit, miss and lost state.
// ----------------------------------------------------------------------------
module epr_ring #(
	parameter int RING_DEPTH = epr_pkg::RING_DEPTH_DEF,
	parameter int SUM_W      = epr_pkg::DIST_W + $clog2(RING_DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  epr_pkg::ring_ctl_t        ctl,
	input  logic [epr_pkg::DIST_W-1:0] wr_data,
	input  logic [epr_pkg::HIT_W-1:0]  hit_threshold,
	output epr_pkg::ring_sts_t        sts,
	output logic [SUM_W-1:0]          sum,
	output logic [epr_pkg::HIT_W-1:0]  hits
);
	import epr_pkg::*;

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [DIST_W-1:0]     mem_q [RING_DEPTH];
	logic [RING_DEPTH-1:0] valid_q;
	logic [IDX_W-1:0]      pos_q;
	logic                  walk_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  rd_vld_s1;
	logic                  last_s1;
	logic                  ent_vld_s1;
	logic [DIST_W-1:0]     rd_data_s1;
	logic [SUM_W-1:0]      sum_q;
	logic [HIT_W-1:0]      hits_q;
	logic [MISS_W-1:0]     misses_q;
	logic                  lost_q;
	logic                  acq_q;

	logic [DIST_W-1:0] entry;
	logic              is_hit;
	logic [HIT_W-1:0]  hits_inc;
	logic [MISS_W-1:0] miss_inc;

	assign entry    = ent_vld_s1 ? rd_data_s1 : '0;
	assign is_hit   = (entry > NEAR_Q8) && (entry < FAR_Q8);
	assign hits_inc = hits_q + HIT_W'(1);
	assign miss_inc = misses_q + MISS_W'(1);

	always_ff @(posedge clk) begin
		if (ctl.write)
			mem_q[pos_q] <= wr_data;
		if (walk_q)
			rd_data_s1 <= mem_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			pos_q      <= '0;
			walk_q     <= 1'b0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			last_s1    <= 1'b0;
			ent_vld_s1 <= 1'b0;
			sum_q      <= '0;
			hits_q     <= '0;
			misses_q   <= '0;
			lost_q     <= 1'b1;
			acq_q      <= 1'b0;
		end else begin
			if (ctl.write) begin
				valid_q[pos_q] <= 1'b1;
				pos_q <= (pos_q == LAST_IDX) ? '0 : pos_q + IDX_W'(1);
			end

			rd_vld_s1 <= walk_q;
			if (walk_q) begin
				ent_vld_s1 <= valid_q[rd_idx_q];
				last_s1    <= rd_idx_q == LAST_IDX;
				if (rd_idx_q == LAST_IDX)
					walk_q <= 1'b0;
				else
					rd_idx_q <= rd_idx_q + IDX_W'(1);
			end

			if (ctl.walk_start) begin
				walk_q   <= 1'b1;
				rd_idx_q <= '0;
				sum_q    <= '0;
				acq_q    <= 1'b0;
			end else if (rd_vld_s1) begin
				sum_q <= sum_q + SUM_W'(entry);
				if (is_hit) begin
					if (hits_inc > hit_threshold) begin
						lost_q <= 1'b0;
						acq_q  <= 1'b1;
					end
					hits_q <= (hits_inc > HIT_WRAP) ? '0 : hits_inc;
				end else begin
					misses_q <= miss_inc;
					if (miss_inc >= MISS_LIMIT)
						lost_q <= 1'b1;
				end
			end
		end
	end

	assign sts.walk_done = rd_vld_s1 && last_s1;
	assign sts.lost      = lost_q;
	assign sts.acquired  = acq_q;
	assign sum           = sum_q;
	assign hits          = hits_q;

endmodule
`default_nettype wire

// ===== rtl/core/echo_pulse_range_filter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// echo_pulse_range_filter_unit - ultrasonic echo pulse ranging filter
// Pulse width to distance, ring mean and hit/miss target tracking.
// ----------------------------------------------------------------------------
// Requests carry cmd in s_tuser and the sampled timer count in s_tdata. A
// wrap tick gives no result. Every echo edge gives one result, worked out
// by the ring walk, which reads one entry per cycle from the ring memory,
// and by the shared constant divider, used for the width/58 conversion on a
// falling edge and for the ring mean on every edge: a reciprocal multiply, a
// back multiply and up to two correction steps. A finished result may wait
// on m_tready. s_tready is low while an edge is in work. The ring is cleared
// at reset through per-entry valid bits, with no clearing pass.
module echo_pulse_range_filter_unit #(
	parameter int RING_DEPTH = epr_pkg::RING_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [15:0]                s_tdata,   // timer_count
	input  logic                       s_tuser,   // cmd
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// distance_q8[26:0], average_q8[53:27], hit_count[75:54], miss_flag[76],
	// acquired_pulse[77], pulse_done[78], zero pad[79]
	output logic [epr_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [epr_pkg::CFG_W-1:0]  cfg_wdata
);
	import epr_pkg::*;

	localparam int SUM_W = DIST_W + $clog2(RING_DEPTH + 1);
	localparam int NUM_W = (SUM_W > DIST_NUM_W) ? SUM_W : DIST_NUM_W;
	localparam logic [SUM_W-1:0] HALF = SUM_W'(RING_DEPTH / 2);

	state_t state_q, state_d;

	logic [TC_W-1:0]       period_q;
	logic [HIT_W-1:0]      thresh_q;
	logic                  awaiting_q;
	logic [TC_W-1:0]       rise_q;
	logic [TC_W-1:0]       tc_q;
	logic [WRAP_W-1:0]     wrap_q;
	logic [PROD_W-1:0]     prod_q;
	logic [DIST_NUM_W-1:0] num_q;
	logic [DIST_W-1:0]     last_q;
	logic                  done_q;

	logic                  m_tvalid_q;
	logic [DIST_W-1:0]     o_dist_q;
	logic [DIST_W-1:0]     o_avg_q;
	logic [HIT_W-1:0]      o_hits_q;
	logic                  o_miss_q;
	logic                  o_acq_q;
	logic                  o_done_q;

	logic                  accept;
	logic                  div_start;
	logic [NUM_W-1:0]      div_numer;
	logic                  div_mean;
	logic                  div_done;
	logic [NUM_W-1:0]      div_quot;
	logic                  load_dist;
	logic                  load_out;
	ring_ctl_t             ring_ctl;
	ring_sts_t             ring_sts;
	logic [SUM_W-1:0]      ring_sum;
	logic [HIT_W-1:0]      ring_hits;

	logic signed [WIDE_W-1:0] wide;
	logic [PROD_W-1:0]        width_w;
	logic [DIST_W-1:0]        dist_sat;

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;

	assign wide = $signed({1'b0, prod_q}) + $signed(WIDE_W'(tc_q)) - $signed(WIDE_W'(rise_q));

	always_comb begin
		if (wrap_q == '0)
			width_w = PROD_W'(TC_W'(tc_q - rise_q));
		else if (wide < 0)
			width_w = '0;
		else
			width_w = wide[PROD_W-1:0];
	end

	assign dist_sat = (div_quot[NUM_W-1:DIST_W] != '0) ? DIST_MAX : div_quot[DIST_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser == CMD_EDGE)
					state_d = awaiting_q ? ST_MUL : ST_WRITE;
			end
			ST_MUL:       state_d = ST_NUM;
			ST_NUM:       state_d = ST_DIST_GO;
			ST_DIST_GO:   state_d = ST_DIST_WAIT;
			ST_DIST_WAIT: if (div_done) state_d = ST_WRITE;
			ST_WRITE:     state_d = ST_WALK_GO;
			ST_WALK_GO:   state_d = ST_WALK;
			ST_WALK:      if (ring_sts.walk_done) state_d = ST_AVG_GO;
			ST_AVG_GO:    state_d = ST_AVG_WAIT;
			ST_AVG_WAIT:  if (div_done) state_d = ST_PUSH;
			ST_PUSH:      if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_start           = (state_q == ST_DIST_GO) || (state_q == ST_AVG_GO);
		div_numer           = (state_q == ST_DIST_GO) ? NUM_W'(num_q) : NUM_W'(ring_sum + HALF);
		div_mean            = state_q == ST_AVG_GO;
		ring_ctl.write      = state_q == ST_WRITE;
		ring_ctl.walk_start = state_q == ST_WALK_GO;
		load_dist           = (state_q == ST_DIST_WAIT) && div_done;
		load_out            = (state_q == ST_PUSH) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			period_q   <= PERIOD_RST;
			thresh_q   <= THRESH_RST;
			awaiting_q <= 1'b0;
			rise_q     <= '0;
			wrap_q     <= '0;
			last_q     <= '0;
			done_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_TIMER_PERIOD:  period_q <= cfg_wdata[TC_W-1:0];
					REG_HIT_THRESHOLD: thresh_q <= cfg_wdata[HIT_W-1:0];
				endcase
			end

			if (accept) begin
				if (s_tuser == CMD_WRAP) begin
					if (wrap_q != WRAP_SAT)
						wrap_q <= wrap_q + WRAP_W'(1);
				end else if (!awaiting_q) begin
					rise_q     <= s_tdata;
					awaiting_q <= 1'b1;
					wrap_q     <= '0;
					done_q     <= 1'b0;
				end else begin
					awaiting_q <= 1'b0;
					done_q     <= 1'b1;
				end
			end

			if (state_q == ST_NUM)
				wrap_q <= '0;
			if (load_dist)
				last_q <= dist_sat;

			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			tc_q <= s_tdata;
		if (state_q == ST_MUL)
			prod_q <= PROD_W'((WRAP_W + 1)'(wrap_q) + (WRAP_W + 1)'(1)) * PROD_W'(period_q);
		if (state_q == ST_NUM)
			num_q <= {width_w, 8'd0} + ROUND_BIAS;
		if (load_out) begin
			o_dist_q <= last_q;
			o_avg_q  <= div_quot[DIST_W-1:0];
			o_hits_q <= ring_hits;
			o_miss_q <= ring_sts.lost;
			o_acq_q  <= ring_sts.acquired;
			o_done_q <= done_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, o_done_q, o_acq_q, o_miss_q, o_hits_q, o_avg_q, o_dist_q};

	epr_div #(
		.NUM_W     (NUM_W),
		.RING_DEPTH(RING_DEPTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.mean_sel(div_mean),
		.numer   (div_numer),
		.done    (div_done),
		.quot    (div_quot)
	);

	epr_ring #(
		.RING_DEPTH(RING_DEPTH),
		.SUM_W     (SUM_W)
	) u_ring (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ring_ctl),
		.wr_data      (last_q),
		.hit_threshold(thresh_q),
		.sts          (ring_sts),
		.sum          (ring_sum),
		.hits         (ring_hits)
	);

	a_walk_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ring_sts.walk_done |-> state_q == ST_WALK)
		else $error("ring walk finished outside walk state");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIST_WAIT || state_q == ST_AVG_WAIT))
		else $error("divider finished outside a wait state");

	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH && m_tvalid_q && !m_tready) |=> state_q == ST_PUSH)
		else $error("result pushed over a pending one");

endmodule
`default_nettype wire

// ===== sim/echo_range_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_range_checker - result checker for the echo pulse range filter
// Watches the request, result and register write ports, runs its own model of
// the pulse width ranging, ring mean and hit/miss tracking, and compares each
// result with the oldest one due. Hands the failure and backlog counts out.
// ----------------------------------------------------------------------------
module echo_range_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [15:0]                s_tdata,
	input  logic                       s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [epr_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [epr_pkg::CFG_W-1:0]  cfg_wdata,
	output int                         fail_count,
	output int                         results_due
);

	localparam int          DEPTH       = epr_pkg::RING_DEPTH_DEF;
	localparam longint      CM_DIV      = 58;
	localparam longint      CM_BIAS     = 29;
	localparam longint      DIST_TOP    = 134217727;
	localparam int unsigned NEAR_2CM    = 512;
	localparam int unsigned FAR_50CM    = 12800;
	localparam int unsigned HIT_ROLL    = 4000000;
	localparam int unsigned WRAP_TOP    = 255;
	localparam logic [7:0]  MISS_LOST   = 8'd5;
	localparam int          PRINT_LIMIT = 100;

	typedef struct {
		logic [26:0] distance;
		logic [26:0] average;
		logic [21:0] hits;
		logic        lost;
		logic        acquired;
		logic        done;
	} range_result_t;

	range_result_t range_queue[$];

	logic [15:0] period_reg;
	logic [21:0] thresh_reg;
	logic        armed;
	logic [15:0] rise_tc;
	int unsigned wraps;
	logic [26:0] dist_now;
	logic [26:0] ring [DEPTH];
	int          slot;
	int unsigned hit_total;
	logic [7:0]  miss_total;
	logic        lost_now;
	int          errs = 0;

	task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
		errs++;
		if (errs <= PRINT_LIMIT)
			$display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
	endtask

	// one echo edge: rise latches, fall measures; both push and walk the ring
	function automatic range_result_t range_step(logic [15:0] tc);
		range_result_t    r;
		longint           span;
		longint           q;
		longint unsigned  sum;
		logic [15:0]      diff;
		r.acquired = 1'b0;
		r.done = 1'b0;
		sum = 0;
		if (!armed) begin
			rise_tc = tc;
			armed = 1'b1;
			wraps = 0;
		end else begin
			armed = 1'b0;
			diff = tc - rise_tc;
			if (wraps == 0)
				span = longint'(diff);
			else
				span = longint'(period_reg) - longint'(rise_tc)
					+ longint'(wraps) * longint'(period_reg) + longint'(tc);
			if (span < 0)
				span = 0;
			q = (span * 256 + CM_BIAS) / CM_DIV;
			if (q > DIST_TOP)
				q = DIST_TOP;
			dist_now = q[26:0];
			wraps = 0;
			r.done = 1'b1;
		end
		ring[slot] = dist_now;
		slot = (slot + 1 == DEPTH) ? 0 : slot + 1;
		foreach (ring[i]) begin
			sum += ring[i];
			if (ring[i] > NEAR_2CM && ring[i] < FAR_50CM) begin
				hit_total++;
				if (hit_total > thresh_reg) begin
					lost_now = 1'b0;
					r.acquired = 1'b1;
				end
				if (hit_total > HIT_ROLL)
					hit_total = 0;
			end else begin
				miss_total = miss_total + 8'd1;
				if (miss_total >= MISS_LOST)
					lost_now = 1'b1;
			end
		end
		r.distance = dist_now;
		r.average = 27'((sum + DEPTH / 2) / DEPTH);
		r.hits = hit_total[21:0];
		r.lost = lost_now;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		range_result_t got;
		range_result_t want;
		if (!arst_n) begin
			period_reg = 16'hFFFF;
			thresh_reg = 22'd100;
			armed = 1'b0;
			rise_tc = '0;
			wraps = 0;
			dist_now = '0;
			foreach (ring[i])
				ring[i] = '0;
			slot = 0;
			hit_total = 0;
			miss_total = '0;
			lost_now = 1'b1;
			range_queue.delete();
			results_due <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					epr_pkg::REG_TIMER_PERIOD:  period_reg = cfg_wdata[15:0];
					epr_pkg::REG_HIT_THRESHOLD: thresh_reg = cfg_wdata;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.distance = m_tdata[26:0];
				got.average = m_tdata[53:27];
				got.hits = m_tdata[75:54];
				got.lost = m_tdata[76];
				got.acquired = m_tdata[77];
				got.done = m_tdata[78];
				if (range_queue.size() == 0) begin
					flag_mismatch("unexpected result, distance_q8", 0, got.distance);
				end else begin
					want = range_queue.pop_front();
					if (got.distance !== want.distance)
						flag_mismatch("distance_q8", want.distance, got.distance);
					if (got.average !== want.average)
						flag_mismatch("average_q8", want.average, got.average);
					if (got.hits !== want.hits)
						flag_mismatch("hit_count", want.hits, got.hits);
					if (got.lost !== want.lost)
						flag_mismatch("miss_flag", want.lost, got.lost);
					if (got.acquired !== want.acquired)
						flag_mismatch("acquired_pulse", want.acquired, got.acquired);
					if (got.done !== want.done)
						flag_mismatch("pulse_done", want.done, got.done);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == epr_pkg::CMD_WRAP) begin
					if (wraps < WRAP_TOP)
						wraps++;
				end else begin
					range_queue.push_back(range_step(s_tdata));
				end
			end
			results_due <= range_queue.size();
			fail_count <= errs;
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - echo pulse range filter unit
// Drives timer wrap ticks and echo edges through the request port under
// random idling on both sides, steps through several register settings
// (extremes included), holds the result side off once to back the block up,
// and takes the verdict from the result checker.
// ----------------------------------------------------------------------------
module testbench;
	import epr_pkg::*;

	localparam int WATCH_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 150;
	localparam int PHASE_ITEMS   = 80;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [15:0]      s_tdata = '0;
	logic             s_tuser = CMD_EDGE;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_we = 1'b0;
	logic             cfg_index = REG_TIMER_PERIOD;
	logic [CFG_W-1:0] cfg_wdata = '0;
	int               fail_count;
	int               results_due;
	bit               calm = 1'b0;
	bit               hold_req = 1'b0;
	int               period_now = 65535;
	int               sent = 0;
	int               stalled = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	echo_pulse_range_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	echo_range_checker range_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	task automatic push_req(logic cmd, logic [15:0] tc);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= tc;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	// rise, some wrap ticks, fall; width mostly inside the 2..50 cm window
	task automatic echo_pulse(int wrap_runs);
		logic [15:0] rise;
		int          span;
		int          fall;
		rise = 16'($urandom);
		span = ($urandom_range(0, 3) != 0) ? $urandom_range(100, 3000)
			: $urandom_range(0, 65535);
		push_req(CMD_EDGE, rise);
		repeat (wrap_runs) push_req(CMD_WRAP, 16'($urandom));
		if (wrap_runs == 0)
			fall = (int'(rise) + span) & 16'hFFFF;
		else
			fall = span - period_now * (wrap_runs + 1) + int'(rise);
		if (fall < 0 || fall > 65535)
			fall = $urandom_range(0, 65535);
		push_req(CMD_EDGE, 16'(fall));
	endtask

	task automatic run_phase(int items);
		int stop;
		stop = sent + items;
		while (sent < stop) begin
			if ($urandom_range(0, 9) == 0)
				push_req(1'($urandom_range(0, 1)), 16'($urandom));
			else
				echo_pulse(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [15:0] period, logic [21:0] thresh);
		cfg_we <= 1'b1;
		cfg_index <= REG_TIMER_PERIOD;
		cfg_wdata <= CFG_W'(period);
		@(posedge clk);
		cfg_index <= REG_HIT_THRESHOLD;
		cfg_wdata <= thresh;
		@(posedge clk);
		cfg_we <= 1'b0;
		period_now = int'(period);
	endtask

	initial begin : sink
		@(posedge clk);
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		while (stalled < WATCH_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				stalled = 0;
			else
				stalled++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	initial begin : stimulus
		logic [16:0] opening [22];
		// stray tick, full-scale and one-count widths, 2 cm and 50 cm edges,
		// widths across wraps and across the 16-bit rollover
		opening = '{
			{CMD_WRAP, 16'hFFFF}, {CMD_EDGE, 16'd0},     {CMD_EDGE, 16'hFFFF},
			{CMD_EDGE, 16'hFFFF}, {CMD_EDGE, 16'd0},     {CMD_EDGE, 16'd100},
			{CMD_WRAP, 16'd0},    {CMD_EDGE, 16'd50},    {CMD_EDGE, 16'd1000},
			{CMD_EDGE, 16'd1116}, {CMD_EDGE, 16'd2000},  {CMD_EDGE, 16'd2117},
			{CMD_EDGE, 16'd5000}, {CMD_EDGE, 16'd7900},  {CMD_EDGE, 16'd5000},
			{CMD_EDGE, 16'd7899}, {CMD_EDGE, 16'd40000}, {CMD_WRAP, 16'd1234},
			{CMD_WRAP, 16'd4321}, {CMD_EDGE, 16'd40000}, {CMD_EDGE, 16'hAAAA},
			{CMD_EDGE, 16'h5555}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i])
			push_req(opening[i][16], opening[i][15:0]);
		settle();
		run_phase(PHASE_ITEMS);
		settle();

		set_config(16'd1, 22'd0);
		// negative width clamps to zero
		push_req(CMD_EDGE, 16'd60000);
		push_req(CMD_WRAP, 16'd0);
		push_req(CMD_EDGE, 16'd10);
		run_phase(PHASE_ITEMS);
		settle();

		set_config(16'hFFFF, 22'd4000000);
		echo_pulse(260);
		run_phase(PHASE_ITEMS);
		settle();

		set_config(16'd1000, 22'd150);
		hold_req = 1'b1;
		run_phase(PHASE_ITEMS);
		settle();

		set_config(16'($urandom_range(1, 65535)), 22'($urandom_range(0, 400)));
		run_phase(PHASE_ITEMS);
		settle();

		calm = 1'b1;
		set_config(16'd50000, 22'd100);
		run_phase(PHASE_ITEMS);
		settle();

		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
